// ===== rtl/rcts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the RC throttle slew and drive block.
package rcts_pkg;

	localparam int unsigned PULSE_W  = 12;
	localparam int unsigned BAND_W   = 10;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned POWER_W  = 8;
	localparam int unsigned CFG_IDX_W = 2;
	// Product of a 12-bit distance and 255 needs 20 bits.
	localparam int unsigned NUM_W    = PULSE_W + POWER_W;

	localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = 12'd1000;
	localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = 12'd2000;
	localparam logic [BAND_W-1:0]  BAND_RST       = 10'd50;
	localparam logic [PULSE_W-1:0] TARGET_RST     = 12'd1500;
	localparam logic [PULSE_W-1:0] TARGET_TOP     = 12'd4095;
	localparam logic [PULSE_W-1:0] STEP_BIG       = 12'd15;
	localparam logic [TIME_W-1:0]  IDLE_HOLD_MS   = 32'd3000;
	localparam logic [POWER_W-1:0] POWER_SAT      = 8'd255;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 2'd2;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_FWD  = 2'd1,
		MODE_REV  = 2'd2
	} mode_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== rtl/rcts_div.sv =====
`timescale 1ns / 1ps
// Restoring divider producing an 8-bit quotient, one quotient bit per cycle.
module rcts_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rcts_pkg::NUM_W-1:0]    numer,
	input  logic [rcts_pkg::PULSE_W-1:0]  denom,
	output rcts_pkg::div_status_t         status,
	output logic [rcts_pkg::POWER_W-1:0]  quotient
);

	logic [rcts_pkg::PULSE_W-1:0] rem_q;
	logic [rcts_pkg::PULSE_W-1:0] den_q;
	logic [rcts_pkg::POWER_W-1:0] low_q;
	logic [rcts_pkg::POWER_W-1:0] quo_q;
	logic [2:0]                   cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [rcts_pkg::PULSE_W:0]   trial;
	logic [rcts_pkg::PULSE_W:0]   diff;
	logic                         qbit;

	// The caller guarantees numer < denom * 256, so the top bits start below denom.
	assign trial = {rem_q, low_q[rcts_pkg::POWER_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd7;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer[rcts_pkg::NUM_W-1:rcts_pkg::POWER_W];
			low_q <= numer[rcts_pkg::POWER_W-1:0];
			den_q <= denom;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[rcts_pkg::PULSE_W-1:0] : trial[rcts_pkg::PULSE_W-1:0];
			low_q <= {low_q[rcts_pkg::POWER_W-2:0], 1'b0};
			quo_q <= {quo_q[rcts_pkg::POWER_W-2:0], qbit};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

// ===== rtl/rc_throttle_slew_drive_top.sv =====
`timescale 1ns / 1ps
// RC throttle slew and drive: target slewing, deadband decision and power scaling.
// Each item passes through the states STEP, EVAL and OUT, and the result register loads on leaving
// OUT; when the power needs a division, DIV lies between EVAL and OUT for the 8 steps and the done
// cycle of the shared divider. A new item is taken only once the previous result has entered the
// output register, which may still be waiting to be taken.
// Reset clears the configuration to 1000/2000/50, the target to 1500 and the active time to 0.
module rc_throttle_slew_drive_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rcts_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rcts_pkg::PULSE_W-1:0]     cfg_data,
	input  logic                             pulse_valid,
	output logic                             pulse_ready,
	input  logic [rcts_pkg::PULSE_W-1:0]     pulse_width,
	input  logic [rcts_pkg::TIME_W-1:0]      now_ms,
	output logic                             result_valid,
	input  logic                             result_ready,
	output logic [1:0]                       drive_mode,
	output logic                             relay_release,
	output logic [rcts_pkg::POWER_W-1:0]     drive_power,
	output logic [rcts_pkg::PULSE_W-1:0]     slewed_target
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_STEP = 5'b00010,
		ST_EVAL = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [rcts_pkg::PULSE_W-1:0] min_q;
	logic [rcts_pkg::PULSE_W-1:0] max_q;
	logic [rcts_pkg::BAND_W-1:0]  band_q;
	logic [rcts_pkg::PULSE_W-1:0] target_q;
	logic [rcts_pkg::TIME_W-1:0]  last_active_q;
	logic [rcts_pkg::PULSE_W-1:0] pulse_q;
	logic [rcts_pkg::TIME_W-1:0]  now_q;
	rcts_pkg::mode_t              mode_q;
	logic                         relay_q;
	logic [rcts_pkg::POWER_W-1:0] power_q;

	logic                         out_valid_q;
	rcts_pkg::mode_t              out_mode_q;
	logic                         out_relay_q;
	logic [rcts_pkg::POWER_W-1:0] out_power_q;
	logic [rcts_pkg::PULSE_W-1:0] out_target_q;

	// Derived thresholds; low is signed and may be negative.
	logic [rcts_pkg::PULSE_W:0]   sum_mm;
	logic [rcts_pkg::PULSE_W-1:0] neutral;
	logic [rcts_pkg::PULSE_W:0]   high;
	logic signed [13:0]           low_s;
	logic signed [13:0]           pulse_s;
	logic signed [13:0]           t_s;

	assign sum_mm  = {1'b0, min_q} + {1'b0, max_q};
	assign neutral = sum_mm[rcts_pkg::PULSE_W:1];
	assign high    = {1'b0, neutral} + {3'b000, band_q};
	assign low_s   = $signed({2'b00, neutral}) - $signed({4'b0000, band_q});
	assign pulse_s = $signed({2'b00, pulse_q});
	assign t_s     = $signed({2'b00, target_q});

	// Target slew.
	logic [rcts_pkg::PULSE_W:0]   t_up15;
	logic [rcts_pkg::PULSE_W:0]   n_plus15;
	logic [rcts_pkg::PULSE_W-1:0] t_next;

	assign t_up15   = {1'b0, target_q} + {1'b0, rcts_pkg::STEP_BIG};
	assign n_plus15 = {1'b0, neutral} + {1'b0, rcts_pkg::STEP_BIG};

	always_comb begin
		t_next = target_q;
		if (pulse_q > target_q) begin
			if ((target_q < neutral) && (pulse_s >= low_s)) begin
				t_next = (t_up15 > {1'b0, neutral}) ? neutral : t_up15[rcts_pkg::PULSE_W-1:0];
			end else if (target_q != rcts_pkg::TARGET_TOP) begin
				t_next = target_q + 12'd1;
			end
		end else begin
			if ((target_q > neutral) && ({1'b0, pulse_q} <= high)) begin
				t_next = ({1'b0, target_q} < n_plus15) ? neutral
				         : (target_q - rcts_pkg::STEP_BIG);
			end else if (target_q != '0) begin
				t_next = target_q - 12'd1;
			end
		end
	end

	// Region decision and power operands on the updated target.
	logic                         in_band;
	logic                         fwd;
	logic [rcts_pkg::PULSE_W:0]   dist_fwd;
	logic signed [13:0]           dist_rev;
	logic signed [13:0]           span_s;
	logic [rcts_pkg::PULSE_W-1:0] pwr_dist;
	logic [rcts_pkg::PULSE_W-1:0] span;
	logic                         span_bad;
	logic                         saturate;
	logic [rcts_pkg::NUM_W-1:0]   numer;
	logic [rcts_pkg::TIME_W-1:0]  idle_ref;

	assign in_band  = (t_s > low_s) && ({1'b0, target_q} < high);
	assign fwd      = ({1'b0, target_q} >= high);
	assign dist_fwd = {1'b0, target_q} - high;
	assign dist_rev = low_s - t_s;

	always_comb begin
		if (fwd) begin
			pwr_dist = dist_fwd[rcts_pkg::PULSE_W-1:0];
			span_s   = $signed({2'b00, max_q}) - $signed({1'b0, high});
		end else begin
			pwr_dist = dist_rev[rcts_pkg::PULSE_W-1:0];
			span_s   = low_s - $signed({2'b00, min_q});
		end
	end

	assign span     = span_s[rcts_pkg::PULSE_W-1:0];
	assign span_bad = (span_s <= 14'sd0);
	// Once the distance reaches the span the scaled power is at least full.
	assign saturate = span_bad || (pwr_dist >= span);
	assign numer    = {pwr_dist, 8'h00} - {8'h00, pwr_dist};
	assign idle_ref = now_q - rcts_pkg::IDLE_HOLD_MS;

	// Shared divider.
	logic                         div_start;
	rcts_pkg::div_status_t        div_status;
	logic [rcts_pkg::POWER_W-1:0] div_quo;

	assign div_start = (state_q == ST_EVAL) && !in_band && !saturate;

	rcts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (numer),
		.denom    (span),
		.status   (div_status),
		.quotient (div_quo)
	);

	logic out_free;
	assign out_free    = !out_valid_q || result_ready;
	assign pulse_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= rcts_pkg::MIN_PULSE_RST;
			max_q  <= rcts_pkg::MAX_PULSE_RST;
			band_q <= rcts_pkg::BAND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcts_pkg::CFG_MIN_PULSE: min_q  <= cfg_data;
				rcts_pkg::CFG_MAX_PULSE: max_q  <= cfg_data;
				rcts_pkg::CFG_DEADBAND:  band_q <= cfg_data[rcts_pkg::BAND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			target_q      <= rcts_pkg::TARGET_RST;
			last_active_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			// A new result may load in the same cycle the old one is taken.
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_valid && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pulse_valid) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					target_q <= t_next;
					state_q  <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!in_band) begin
						last_active_q <= now_q;
					end
					state_q <= div_start ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (div_status.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pulse_valid && pulse_ready) begin
			pulse_q <= pulse_width;
			now_q   <= now_ms;
		end
		if (state_q == ST_EVAL) begin
			if (in_band) begin
				mode_q  <= rcts_pkg::MODE_IDLE;
				relay_q <= (idle_ref > last_active_q);
				power_q <= '0;
			end else begin
				mode_q  <= fwd ? rcts_pkg::MODE_FWD : rcts_pkg::MODE_REV;
				relay_q <= 1'b0;
				power_q <= rcts_pkg::POWER_SAT;
			end
		end
		if ((state_q == ST_DIV) && div_status.done) begin
			power_q <= div_quo;
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_mode_q   <= mode_q;
			out_relay_q  <= relay_q;
			out_power_q  <= power_q;
			out_target_q <= target_q;
		end
	end

	assign result_valid  = out_valid_q;
	assign drive_mode    = out_mode_q;
	assign relay_release = out_relay_q;
	assign drive_power   = out_power_q;
	assign slewed_target = out_target_q;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RC throttle slew and drive block.
module tb;
	import rcts_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int CYCLE_LIMIT = 300000;
	localparam int N_PHASES    = 12;

	typedef struct {
		mode_t             mode;
		logic              relay;
		logic [POWER_W-1:0] power;
		logic [PULSE_W-1:0] target;
	} drive_result_t;

	// Tracks target slewing and the drive decision, and checks each result transaction.
	class drive_scoreboard;
		int min_w, max_w, band;
		int target;
		logic [TIME_W-1:0] last_active;
		drive_result_t pending_drive[$];
		int checked, failures;
		int n_fwd, n_rev, n_idle, n_relay, n_full;

		function new();
			min_w = int'(MIN_PULSE_RST);
			max_w = int'(MAX_PULSE_RST);
			band = int'(BAND_RST);
			target = int'(TARGET_RST);
			last_active = '0;
		endfunction

		function void configure(int mn, int mx, int db);
			min_w = mn;
			max_w = mx;
			band = db;
		endfunction

		function logic [POWER_W-1:0] scaled_power(int offset, int span);
			int p;
			if (span <= 0)
				return POWER_SAT;
			p = offset * int'(POWER_SAT) / span;
			if (p > int'(POWER_SAT))
				p = int'(POWER_SAT);
			if (p < 0)
				p = 0;
			return p[POWER_W-1:0];
		endfunction

		function void note_pulse(logic [PULSE_W-1:0] pw, logic [TIME_W-1:0] now);
			int pulse, neutral, hi, lo, t, jump;
			drive_result_t r;
			pulse = int'(pw);
			jump = int'(STEP_BIG);
			neutral = (min_w + max_w) / 2;
			hi = neutral + band;
			lo = neutral - band;
			t = target;
			// Coming back toward the deadband pulls a far target to neutral quickly.
			if (pulse > t) begin
				if (t < neutral && pulse >= lo) begin
					t = t + jump;
					if (t > neutral)
						t = neutral;
				end else if (t < int'(TARGET_TOP)) begin
					t = t + 1;
				end
			end else begin
				if (t > neutral && pulse <= hi) begin
					t = t - jump;
					if (t < neutral)
						t = neutral;
				end else if (t > 0) begin
					t = t - 1;
				end
			end
			target = t;
			r.mode = MODE_IDLE;
			r.relay = 1'b0;
			r.power = '0;
			r.target = t[PULSE_W-1:0];
			if (t > lo && t < hi) begin
				r.relay = ((now - IDLE_HOLD_MS) > last_active);
				n_idle++;
				if (r.relay)
					n_relay++;
			end else begin
				last_active = now;
				if (t >= hi) begin
					r.mode = MODE_FWD;
					r.power = scaled_power(t - hi, max_w - hi);
					n_fwd++;
				end else begin
					r.mode = MODE_REV;
					r.power = scaled_power(lo - t, lo - min_w);
					n_rev++;
				end
				if (r.power == POWER_SAT)
					n_full++;
			end
			pending_drive.push_back(r);
		endfunction

		function void check_result(logic [1:0] mode, logic relay, logic [POWER_W-1:0] power,
				logic [PULSE_W-1:0] tgt);
			drive_result_t e;
			checked++;
			if (pending_drive.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("tb: result transaction %0d with nothing expected", checked);
				return;
			end
			e = pending_drive.pop_front();
			if (mode !== e.mode || relay !== e.relay || power !== e.power || tgt !== e.target) begin
				failures++;
				if (failures <= 10) begin
					$display("tb: mismatch at result %0d (expected/actual):", checked);
					$display("tb:   mode %0d/%0d relay %0d/%0d power %0d/%0d target %0d/%0d",
						e.mode, mode, e.relay, relay, e.power, power, e.target, tgt);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PULSE_W-1:0]   cfg_data;
	logic                 pulse_valid;
	logic                 pulse_ready;
	logic [PULSE_W-1:0]   pulse_width;
	logic [TIME_W-1:0]    now_ms;
	logic                 result_valid;
	logic                 result_ready;
	logic [1:0]           drive_mode;
	logic                 relay_release;
	logic [POWER_W-1:0]   drive_power;
	logic [PULSE_W-1:0]   slewed_target;

	drive_scoreboard sb = new();
	bit calm = 1'b0;
	int cycles = 0;
	int settings = 1;
	logic [TIME_W-1:0] clock_ms = '0;

	rc_throttle_slew_drive_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pulse_valid  (pulse_valid),
		.pulse_ready  (pulse_ready),
		.pulse_width  (pulse_width),
		.now_ms       (now_ms),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.drive_mode   (drive_mode),
		.relay_release(relay_release),
		.drive_power  (drive_power),
		.slewed_target(slewed_target)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic int rnd(int lo, int hi);
		return lo + int'($urandom_range(hi - lo, 0));
	endfunction

	function automatic int clamp_pulse(int p);
		if (p < 0)
			return 0;
		if (p > int'(TARGET_TOP))
			return int'(TARGET_TOP);
		return p;
	endfunction

	// Mostly small forward steps, with wraps, wild jumps and the relay threshold itself.
	function automatic logic [TIME_W-1:0] advance_clock_ms();
		int pick;
		pick = rnd(0, 99);
		if (pick < 2)
			clock_ms = $urandom;
		else if (pick < 4)
			clock_ms = 32'hFFFF_FFFF - rnd(0, 400);
		else if (pick < 7)
			clock_ms = sb.last_active + IDLE_HOLD_MS + rnd(0, 1);
		else
			clock_ms = clock_ms + rnd(0, 150);
		return clock_ms;
	endfunction

	task automatic feed(logic [PULSE_W-1:0] pw, logic [TIME_W-1:0] t);
		if (!calm && rnd(0, 3) == 0) begin
			pulse_valid <= 1'b0;
			repeat (rnd(1, 5)) @(posedge clk);
		end
		pulse_valid <= 1'b1;
		pulse_width <= pw;
		now_ms <= t;
		do @(negedge clk); while (pulse_ready !== 1'b1);
		@(posedge clk);
		sb.note_pulse(pw, t);
	endtask

	task automatic settle();
		pulse_valid <= 1'b0;
		while (sb.pending_drive.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic program_regs(int mn, int mx, int db);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_PULSE;
		cfg_data <= mn[PULSE_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_MAX_PULSE;
		cfg_data <= mx[PULSE_W-1:0];
		@(posedge clk);
		cfg_index <= CFG_DEADBAND;
		cfg_data <= {2'b00, db[BAND_W-1:0]};
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.configure(mn, mx, db);
		settings++;
	endtask

	// Runs of pulses that hold a direction long enough for the target to follow.
	task automatic run_phase(int count, bit pull_down);
		int kind, run_len, neutral, p;
		kind = 0;
		run_len = 0;
		for (int i = 0; i < count; i++) begin
			if (run_len == 0) begin
				kind = rnd(0, 9);
				run_len = rnd(3, 25);
			end
			run_len--;
			neutral = (sb.min_w + sb.max_w) / 2;
			case (kind)
				0, 1, 2: p = sb.target + rnd(1, 300);
				3, 4, 5: p = sb.target - rnd(1, 300);
				6:       p = neutral - sb.band + rnd(0, 2 * sb.band);
				7:       p = sb.target + rnd(-1, 1);
				8:       p = (rnd(0, 1) == 1) ? int'(TARGET_TOP) : 0;
				default: p = rnd(0, int'(TARGET_TOP));
			endcase
			if (pull_down && rnd(0, 4) != 0)
				p = 0;
			feed(clamp_pulse(p), advance_clock_ms());
		end
	endtask

	initial begin : result_side
		int burst, hold;
		bit fire, held_once;
		logic [1:0] m;
		logic rl;
		logic [POWER_W-1:0] pw;
		logic [PULSE_W-1:0] tg;
		burst = 0;
		hold = 0;
		held_once = 1'b0;
		result_ready <= 1'b0;
		forever begin
			@(negedge clk);
			fire = (result_valid === 1'b1) && (result_ready === 1'b1);
			m = drive_mode;
			rl = relay_release;
			pw = drive_power;
			tg = slewed_target;
			@(posedge clk);
			if (fire)
				sb.check_result(m, rl, pw, tg);
			// One long hold-off so the block backs up and stalls its input.
			if (!held_once && sb.checked == 500) begin
				held_once = 1'b1;
				hold = 250;
			end
			if (hold > 0) begin
				hold--;
				result_ready <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				result_ready <= 1'b0;
			end else if (!calm && rnd(0, 4) == 0) begin
				burst = rnd(0, 4);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin : pulse_side
		int mn, mx, db, c, half, tmp;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MIN_PULSE;
		cfg_data <= '0;
		pulse_valid <= 1'b0;
		pulse_width <= '0;
		now_ms <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: relay threshold around 3000 ms and time wrap.
		feed(12'd1500, 32'd0);
		feed(12'd4095, 32'hFFFF_FFFF);
		feed(12'd0, 32'd2999);
		feed(12'd1500, 32'd3000);
		feed(12'd1500, 32'd3001);
		settle();

		// Narrow spans: forward saturation, snap back to neutral, reverse, snap from below.
		program_regs(1494, 1506, 2);
		for (int i = 0; i < 8; i++)
			feed(12'd4095, 32'd4000 + 20 * i);
		feed(12'd1500, 32'd4200);
		for (int i = 0; i < 5; i++)
			feed(12'd0, 32'd4220 + 20 * i);
		feed(12'd1499, 32'd4400);
		settle();

		// Zero span on both sides with an empty deadband.
		program_regs(1500, 1500, 0);
		feed(12'd4095, 32'd4420);
		feed(12'd4095, 32'd4440);
		feed(12'd0, 32'd4460);
		feed(12'd0, 32'd4480);
		clock_ms = 32'd4480;

		for (int k = 0; k < N_PHASES; k++) begin
			settle();
			case (k)
				0: begin mn = 0; mx = 0; db = 0; end
				1: begin mn = 0; mx = int'(TARGET_TOP); db = 1023; end
				2: begin mn = int'(TARGET_TOP); mx = 0; db = 0; end
				3: begin mn = int'(TARGET_TOP); mx = int'(TARGET_TOP); db = 1023; end
				default: begin
					c = sb.target + rnd(-60, 60);
					half = (rnd(0, 3) == 0) ? rnd(0, 2000) : rnd(0, 150);
					db = (rnd(0, 3) == 0) ? rnd(0, 1023) : rnd(0, 40);
					mn = clamp_pulse(c - half);
					mx = clamp_pulse(c + half);
					if (rnd(0, 5) == 0) begin
						tmp = mn;
						mn = mx;
						mx = tmp;
					end
				end
			endcase
			program_regs(mn, mx, db);
			if (k == N_PHASES - 1)
				calm = 1'b1;
			// The first phase drags the target down to zero so it sits at the bottom end.
			run_phase((k == 0) ? 130 : 85, k == 0);
		end

		pulse_valid <= 1'b0;
		while (sb.pending_drive.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("tb: %0d results checked over %0d register settings, %0d failures",
			sb.checked, settings, sb.failures);
		$display("tb: forward %0d, reverse %0d, idle %0d, relay releases %0d, full power %0d",
			sb.n_fwd, sb.n_rev, sb.n_idle, sb.n_relay, sb.n_full);
		if (sb.failures == 0 && sb.pending_drive.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rcts_pkg.sv
rtl/rcts_div.sv
rtl/rc_throttle_slew_drive_top.sv
dv/tb.sv
